// ===== design/c16fc_pkg.sv =====
// ----------------------------------------------------------------------------
// c16fc_pkg
// Shared types, constants and the byte-wide CRC fold for the CRC-16 checker.
// ----------------------------------------------------------------------------
package c16fc_pkg;

   localparam logic [15:0] CRC_POLY       = 16'h8408;
   localparam logic [15:0] CRC_PRESET_RST = 16'hFFFF;
   localparam int          CSR_IDX_W      = 2;
   localparam int          CSR_DATA_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CRC_PRESET    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_LAST_TWO = 2'd1;

   typedef struct packed {
      logic [15:0] crc;
      logic [7:0]  held_byte;
      logic        held_valid;
      logic        active;
   } state_type;

   function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/crc16_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_checker_top
// Reflected CRC-16 (poly 0x8408) over byte frames, optional swap of last two.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one frame byte per beat in req_tdata[7:0]; req_tlast marks the
//            final byte of a frame.
//   rsp_*  : one beat per frame, the inverted CRC in rsp_tdata[15:0].
//   csr_*  : register writes; index 0 = crc_preset, 1 = swap_last_two,
//            other indexes are ignored. Always ready. Write only while idle.
// Timing:
//   A byte enters the input register, the CRC update works on it from there
//   and the result register loads as the last byte advances, raising
//   rsp_tvalid. One byte per cycle sustained unless a last byte waits on
//   the output; the CRC register loop closes through at most two byte folds.
// Reset:
//   Clears both beat registers and the frame state; crc_preset returns to
//   0xFFFF and swap_last_two to 0.
// Stall:
//   While rsp_tready is low and a result waits, bytes that are not last keep
//   flowing; a last byte holds in the input register and req_tready drops.
// ----------------------------------------------------------------------------
module crc16_frame_checker_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // [15:0] crc_value
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [c16fc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [c16fc_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [15:0]          preset_ff;
   logic                 swap_ff;
   logic                 in_vld_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   c16fc_pkg::state_type state_ff;
   c16fc_pkg::state_type state_in;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   logic [15:0]          out_crc_ff;
   logic [15:0]          crc_result;
   logic                 out_free;
   logic                 advance;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_vld_ff | rsp_tready;
   assign advance    = in_vld_ff & (!in_last_ff | out_free);
   assign req_tready = !in_vld_ff | advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_crc_ff;

   c16fc_update u_update (
      .state_cur     (state_ff),
      .crc_preset    (preset_ff),
      .swap_last_two (swap_ff),
      .data_byte     (in_byte_ff),
      .last_byte     (in_last_ff),
      .state_next    (state_in),
      .crc_value     (crc_result)
   );

   always_comb begin
      out_vld_in = out_vld_ff & !rsp_tready;
      if (advance & in_last_ff) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff <= c16fc_pkg::CRC_PRESET_RST;
         swap_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            c16fc_pkg::CSR_CRC_PRESET:    preset_ff <= csr_data;
            c16fc_pkg::CSR_SWAP_LAST_TWO: swap_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.crc        <= c16fc_pkg::CRC_PRESET_RST;
         state_ff.held_byte  <= 8'h00;
         state_ff.held_valid <= 1'b0;
         state_ff.active     <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance & in_last_ff) begin
         out_crc_ff <= crc_result;
      end
   end

endmodule

// ===== design/c16fc_update.sv =====
// ----------------------------------------------------------------------------
// c16fc_update
// Next-state logic for one byte: frame start, hold-back and up to two folds.
// ----------------------------------------------------------------------------
module c16fc_update (
   input  c16fc_pkg::state_type state_cur,
   input  logic [15:0]          crc_preset,
   input  logic                 swap_last_two,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output c16fc_pkg::state_type state_next,
   output logic [15:0]          crc_value
);

   logic [15:0] base_crc;
   logic        base_hv;
   logic        swap_end;
   logic [7:0]  first_byte;
   logic [7:0]  second_byte;
   logic        first_en;
   logic        second_en;
   logic [15:0] crc_a;
   logic [15:0] crc_b;

   always_comb begin
      base_crc    = state_cur.active ? state_cur.crc : crc_preset;
      base_hv     = state_cur.active & state_cur.held_valid;
      swap_end    = swap_last_two & last_byte;
      // swapped end folds the new byte before the held one
      first_byte  = swap_end ? data_byte : state_cur.held_byte;
      second_byte = swap_end ? state_cur.held_byte : data_byte;
      first_en    = swap_end | base_hv;
      second_en   = swap_end ? base_hv : !swap_last_two;

      crc_a = first_en ? c16fc_pkg::fold_byte(base_crc, first_byte) : base_crc;
      crc_b = second_en ? c16fc_pkg::fold_byte(crc_a, second_byte) : crc_a;

      state_next.crc        = crc_b;
      state_next.active     = !last_byte;
      state_next.held_valid = swap_last_two & !last_byte;
      state_next.held_byte  = (swap_last_two & !last_byte) ? data_byte : 8'h00;
      crc_value             = ~crc_b;
   end

endmodule

// ===== sim/crc16_frame_crc_monitor.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_crc_monitor
// Watches the byte, result and register channels of the CRC-16 frame checker,
// keeps its own copy of the running CRC, swap hold-back and register values,
// predicts the inverted CRC of every completed frame and compares each result
// beat in order against it.
// ----------------------------------------------------------------------------
module crc16_frame_crc_monitor
   import c16fc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    crc_errors,
   output int                    crc_owed
);

   logic [15:0] crc_due[$];
   logic [15:0] preset_reg;
   logic        swap_reg;
   logic [15:0] run_crc;
   logic [7:0]  held_byte;
   logic        held_ok;
   logic        in_frame;
   logic [15:0] next_crc;
   logic [15:0] want_crc;
   int          mismatch_count = 0;

   function automatic logic [15:0] crc_fold_bits(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r  = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         preset_reg = CRC_PRESET_RST;
         swap_reg   = 1'b0;
         run_crc    = CRC_PRESET_RST;
         held_byte  = 8'h00;
         held_ok    = 1'b0;
         in_frame   = 1'b0;
         crc_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CRC_PRESET: begin
                  preset_reg = csr_data[15:0];
               end
               CSR_SWAP_LAST_TWO: begin
                  swap_reg = csr_data[0];
               end
               default: begin
               end
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (crc_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: crc result %04h arrived with none expected", $time, rsp_tdata);
               end
            end else begin
               want_crc = crc_due.pop_front();
               if (rsp_tdata !== want_crc) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: crc_value expected %04h actual %04h",
                              $time, want_crc, rsp_tdata);
                  end
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (!in_frame) begin
               run_crc  = preset_reg;
               held_ok  = 1'b0;
               in_frame = 1'b1;
            end
            next_crc = run_crc;
            if (swap_reg) begin
               if (req_tlast) begin
                  next_crc = crc_fold_bits(next_crc, req_tdata);
                  if (held_ok) begin
                     next_crc = crc_fold_bits(next_crc, held_byte);
                  end
               end else begin
                  if (held_ok) begin
                     next_crc = crc_fold_bits(next_crc, held_byte);
                  end
                  held_byte = req_tdata;
                  held_ok   = 1'b1;
               end
            end else begin
               if (held_ok) begin
                  next_crc = crc_fold_bits(next_crc, held_byte);
                  held_ok  = 1'b0;
               end
               next_crc = crc_fold_bits(next_crc, req_tdata);
            end
            run_crc = next_crc;
            if (req_tlast) begin
               crc_due.push_back(~next_crc);
               held_ok  = 1'b0;
               in_frame = 1'b0;
            end
         end
      end
      crc_errors <= mismatch_count;
      crc_owed   <= crc_due.size();
   end

endmodule

// ===== sim/crc16_frame_checker_top_test.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_checker_top_test
// Drives byte frames and register writes into the CRC-16 frame checker with
// random idle and stall bursts: a directed set for the check string, one-byte
// frames, swap mode and mid-frame register changes, then random frames under
// several preset and swap settings. The CRC monitor judges every result.
// ----------------------------------------------------------------------------
module crc16_frame_checker_top_test;
   import c16fc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   int                    crc_errors;
   int                    crc_owed;
   bit                    calm = 1'b0;

   always #2 clock = ~clock;

   crc16_frame_checker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   crc16_frame_crc_monitor crc_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .crc_errors (crc_errors),
      .crc_owed   (crc_owed)
   );

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold the byte stream until every result is in and the pipeline is empty
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (crc_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
         if (!calm && i < len - 1 && $urandom_range(0, 39) == 0) begin
            drain_results();
            if ($urandom_range(0, 1) == 0) begin
               write_csr(CSR_SWAP_LAST_TWO, 16'($urandom_range(0, 1)));
            end else begin
               write_csr(CSR_CRC_PRESET, 16'($urandom_range(0, 65535)));
            end
         end
      end
   endtask

   // result side: random stall bursts, none once the run turns calm
   initial begin
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      #2000000;
      $display("** crc16_frame_checker_top: FAILED **");
      $finish;
   end

   initial begin
      int          sent;
      int          len;
      logic [15:0] preset;
      logic        swap;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: check string, one-byte frames at both extremes
      for (int i = 0; i < 9; i++) begin
         send_byte(8'h31 + 8'(i), i == 8);
      end
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);

      drain_results();
      write_csr(CSR_CRC_PRESET, 16'h0000);
      write_csr(CSR_SWAP_LAST_TWO, 16'h0001);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);

      // swap turned off mid-frame
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      drain_results();
      write_csr(CSR_SWAP_LAST_TWO, 16'h0000);
      send_byte(8'h01, 1'b1);

      // swap turned on mid-frame
      send_byte(8'h5A, 1'b0);
      send_byte(8'hC3, 1'b0);
      drain_results();
      write_csr(CSR_SWAP_LAST_TWO, 16'h0001);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h7E, 1'b1);

      // preset changed mid-frame, then writes to unused indexes
      send_byte(8'h99, 1'b0);
      drain_results();
      write_csr(CSR_CRC_PRESET, 16'hFFFF);
      send_byte(8'h66, 1'b1);
      drain_results();
      write_csr(CSR_SPARE_A, 16'h5A5A);
      write_csr(CSR_SPARE_B, 16'h0000);
      send_byte(8'h42, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               preset = 16'hFFFF;
               swap   = 1'b0;
            end
            1: begin
               preset = 16'h0000;
               swap   = 1'b1;
            end
            2: begin
               preset = 16'hFFFF;
               swap   = 1'b1;
            end
            3: begin
               preset = 16'h0000;
               swap   = 1'b0;
            end
            default: begin
               preset = 16'($urandom_range(0, 65535));
               swap   = 1'($urandom_range(0, 1));
            end
         endcase
         drain_results();
         write_csr(CSR_CRC_PRESET, preset);
         write_csr(CSR_SWAP_LAST_TWO, {15'h0000, swap});
         calm = (phase == 5);
         sent = 0;
         while (sent < 200) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_frame(len);
            sent += len;
         end
      end

      req_tvalid <= 1'b0;
      while (crc_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (crc_errors == 0 && crc_owed == 0) begin
         $display("** crc16_frame_checker_top: PASSED **");
      end else begin
         $display("** crc16_frame_checker_top: FAILED **");
      end
      $finish;
   end

endmodule
